/* sv/assert_macros.svh */
// Assertion helpers shared by the expander modules.
// Each use expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCXRLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcxrle: assertion failed");

// Next-cycle implication, checked outside reset.
`define PCXRLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcxrle: assertion failed");

`endif

/* sv/pcxrle_pkg.sv */
package pcxrle_pkg;

  // Run count marker: both top bits set, count in the low six bits.
  localparam logic [7:0] RUN_MARK = 8'hC0;
  localparam logic [7:0] RUN_MASK = 8'h3F;

  // Configuration register indexes.
  localparam logic [2:0] REG_BYTES_PER_LINE    = 3'd0;
  localparam logic [2:0] REG_LINE_TOTAL        = 3'd1;
  localparam logic [2:0] REG_START_COLUMN_BYTE = 3'd2;
  localparam logic [2:0] REG_START_ROW         = 3'd3;
  localparam logic [2:0] REG_COLUMN_LIMIT      = 3'd4;
  localparam logic [2:0] REG_ROW_LIMIT         = 3'd5;
  localparam logic [2:0] REG_FG_COLOR          = 3'd6;
  localparam logic [2:0] REG_BG_COLOR          = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Command queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [10:0] bytes_per_line;
    logic [12:0] line_total;
    logic [6:0]  start_column_byte;
    logic [11:0] start_row;
    logic [6:0]  column_limit;
    logic [11:0] row_limit;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;
  } cfg_t;

  // One drawing request: a decoded byte repeated over consecutive columns.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [6:0]  col;
    logic [11:0] row;
    logic [5:0]  count;
    logic        done;
  } cmd_t;

endpackage

/* sv/pcxrle_in_if.sv */
interface pcxrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

/* sv/pcxrle_out_if.sv */
interface pcxrle_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_colors;
  logic [9:0]  pixel_x;
  logic [11:0] pixel_y;
  logic        last_of_run;
  logic        image_done;

  modport source (output valid, output pixel_colors, output pixel_x, output pixel_y,
                  output last_of_run, output image_done, input ready);
  modport sink (input valid, input pixel_colors, input pixel_x, input pixel_y,
                input last_of_run, input image_done, output ready);
endinterface

/* sv/pcxrle_front.sv */
`include "assert_macros.svh"

module pcxrle_front (
  input  logic                clk,
  input  logic                rst_n,
  input  pcxrle_pkg::cfg_t    cfg,
  pcxrle_in_if.sink           in_ch,
  input  logic                q_full,
  output logic                q_push,
  output pcxrle_pkg::cmd_t    q_data
);

  logic        pend_r, pend_nxt;
  logic [5:0]  rlen_r, rlen_nxt;
  logic [10:0] idx_r, idx_nxt;
  logic [12:0] lc_r, lc_nxt;
  logic        fin_r, fin_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        start_end;
  logic        is_count;
  logic [5:0]  reps;
  logic [11:0] idx_inc;
  logic [10:0] rem;
  logic        line_done;
  logic [5:0]  n;
  logic [10:0] bpl_m2;
  logic [10:0] by_len;
  logic [11:0] col_sum;
  logic [6:0]  by_col;
  logic [5:0]  cnt;
  logic [12:0] lc_inc;
  logic        fin_after;

  // The image ends when the line count, the start column or the row runs out.
  function automatic logic image_end(input logic [12:0] lc, input pcxrle_pkg::cfg_t c);
    logic [13:0] row_sum;
    row_sum = {2'b00, c.start_row} + {1'b0, lc};
    return (lc >= c.line_total) || (c.start_column_byte > c.column_limit) ||
           (row_sum > {2'b00, c.row_limit});
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  // Classify the byte and work out how far a run reaches in the current line.
  always_comb begin
    start_end = (idx_r == 11'd0) && image_end(lc_r, cfg);
    is_count  = !pend_r && ((b & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK);
    reps      = pend_r ? rlen_r : 6'd1;

    // A line whose length was lowered below the index ends at the next byte.
    idx_inc   = {1'b0, idx_r} + 12'd1;
    rem       = (idx_inc >= {1'b0, cfg.bytes_per_line}) ? 11'd1
                                                        : cfg.bytes_per_line - idx_r;
    line_done = (reps != 6'd0) && ({5'b0, reps} >= rem);
    n         = line_done ? rem[5:0] : reps;

    // Drawn bytes form a prefix of the run, bounded by the line and the screen.
    bpl_m2  = cfg.bytes_per_line - 11'd2;
    by_len  = ((cfg.bytes_per_line > 11'd2) && (idx_r < bpl_m2)) ? bpl_m2 - idx_r : 11'd0;
    col_sum = {5'b0, cfg.start_column_byte} + {1'b0, idx_r};
    by_col  = (col_sum < {5'b0, cfg.column_limit}) ? cfg.column_limit - col_sum[6:0]
                                                  : 7'd0;
    cnt = n;
    if (by_len < {5'b0, cnt}) begin
      cnt = by_len[5:0];
    end
    if (by_col < {1'b0, cnt}) begin
      cnt = by_col[5:0];
    end

    lc_inc    = lc_r + 13'd1;
    fin_after = line_done && image_end(lc_inc, cfg);
  end

  // Next state of the decoder.
  always_comb begin
    pend_nxt = pend_r;
    rlen_nxt = rlen_r;
    idx_nxt  = idx_r;
    lc_nxt   = lc_r;
    fin_nxt  = fin_r;
    if (accept && !fin_r) begin
      if (start_end) begin
        fin_nxt = 1'b1;
      end else if (is_count) begin
        pend_nxt = 1'b1;
        rlen_nxt = b[5:0] & pcxrle_pkg::RUN_MASK[5:0];
      end else begin
        pend_nxt = 1'b0;
        rlen_nxt = 6'd0;
        if (line_done) begin
          idx_nxt = 11'd0;
          lc_nxt  = lc_inc;
          fin_nxt = fin_after;
        end else begin
          idx_nxt = idx_r + {5'b0, n};
        end
      end
    end
  end

  // Hand a drawing request to the back when at least one byte is drawn.
  always_comb begin
    q_push         = accept && !fin_r && !start_end && !is_count && (cnt != 6'd0);
    q_data.data_byte = b;
    q_data.col     = col_sum[6:0];
    q_data.row     = cfg.start_row + lc_r[11:0];
    q_data.count   = cnt;
    q_data.done    = fin_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      rlen_r <= 6'd0;
      idx_r  <= 11'd0;
      lc_r   <= 13'd0;
      fin_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      rlen_r <= rlen_nxt;
      idx_r  <= idx_nxt;
      lc_r   <= lc_nxt;
      fin_r  <= fin_nxt;
    end
  end

  `PCXRLE_ASSERT_IMP(a_no_push_after_end, fin_r, !q_push)
  `PCXRLE_ASSERT_NXT(a_end_sticks, fin_r, fin_r)

endmodule

/* sv/pcxrle_fifo.sv */
`include "assert_macros.svh"

module pcxrle_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pcxrle_pkg::cmd_t push_data,
  output logic             full,
  input  logic             pop,
  output pcxrle_pkg::cmd_t pop_data,
  output logic             empty
);

  pcxrle_pkg::cmd_t                     mem_r [pcxrle_pkg::Q_DEPTH];
  logic [pcxrle_pkg::Q_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [pcxrle_pkg::Q_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [pcxrle_pkg::Q_CNT_W-1:0]       count_r, count_nxt;

  assign full     = (count_r == pcxrle_pkg::Q_CNT_W'(pcxrle_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `PCXRLE_ASSERT_IMP(a_no_overflow, push, !full)
  `PCXRLE_ASSERT_IMP(a_no_underflow, pop, !empty)

endmodule

/* sv/pcxrle_back.sv */
`include "assert_macros.svh"

module pcxrle_back #(
  parameter int COLOR_BITS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pcxrle_pkg::cfg_t cfg,
  input  logic             q_empty,
  input  pcxrle_pkg::cmd_t q_data,
  output logic             q_pop,
  pcxrle_out_if.source     out_ch
);

  localparam int WordW = (8 * COLOR_BITS > 32) ? 8 * COLOR_BITS : 32;

  // Request being expanded.
  logic        act_valid_r, act_valid_nxt;
  logic [7:0]  act_byte_r, act_byte_nxt;
  logic [6:0]  act_col_r, act_col_nxt;
  logic [11:0] act_row_r, act_row_nxt;
  logic [5:0]  act_cnt_r, act_cnt_nxt;
  logic        act_done_r, act_done_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_colors_r, out_colors_nxt;
  logic [9:0]  out_x_r, out_x_nxt;
  logic [11:0] out_y_r, out_y_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_done_r, out_done_nxt;

  logic                  advance;
  logic                  act_ends;
  logic [COLOR_BITS-1:0] fg_code;
  logic [COLOR_BITS-1:0] bg_code;
  logic [WordW-1:0]      word;

  // Expand the byte into eight color codes, leftmost pixel on top.
  always_comb begin
    fg_code = COLOR_BITS'(cfg.fg_color);
    bg_code = COLOR_BITS'(cfg.bg_color);
    word    = '0;
    for (int j = 0; j < 8; j++) begin
      word[j*COLOR_BITS +: COLOR_BITS] = act_byte_r[j] ? fg_code : bg_code;
    end
  end

  assign advance  = act_valid_r && (!out_valid_r || out_ch.ready);
  assign act_ends = advance && (act_cnt_r == 6'd1);
  assign q_pop    = !q_empty && (!act_valid_r || act_ends);

  // Step through the run one column per result.
  always_comb begin
    act_valid_nxt = act_valid_r;
    act_byte_nxt  = act_byte_r;
    act_col_nxt   = act_col_r;
    act_row_nxt   = act_row_r;
    act_cnt_nxt   = act_cnt_r;
    act_done_nxt  = act_done_r;
    if (q_pop) begin
      act_valid_nxt = 1'b1;
      act_byte_nxt  = q_data.data_byte;
      act_col_nxt   = q_data.col;
      act_row_nxt   = q_data.row;
      act_cnt_nxt   = q_data.count;
      act_done_nxt  = q_data.done;
    end else if (advance) begin
      act_valid_nxt = !act_ends;
      act_col_nxt   = act_col_r + 7'd1;
      act_cnt_nxt   = act_cnt_r - 6'd1;
    end
  end

  // Load the output register from the active request whenever it is empty or being drained.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_colors_nxt = out_colors_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    if (advance) begin
      out_valid_nxt  = 1'b1;
      out_colors_nxt = word[31:0];
      out_x_nxt      = {act_col_r, 3'b000};
      out_y_nxt      = act_row_r;
      out_last_nxt   = (act_cnt_r == 6'd1);
      out_done_nxt   = act_done_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_valid_r <= act_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_byte_r   <= act_byte_nxt;
    act_col_r    <= act_col_nxt;
    act_row_r    <= act_row_nxt;
    act_cnt_r    <= act_cnt_nxt;
    act_done_r   <= act_done_nxt;
    out_colors_r <= out_colors_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_last_r   <= out_last_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_colors = out_colors_r;
  assign out_ch.pixel_x      = out_x_r;
  assign out_ch.pixel_y      = out_y_r;
  assign out_ch.last_of_run  = out_last_r;
  assign out_ch.image_done   = out_done_r;

  `PCXRLE_ASSERT_IMP(a_active_has_work, act_valid_r, act_cnt_r != 6'd0)
  `PCXRLE_ASSERT_NXT(a_result_follows_step, advance, out_valid_r)

endmodule

/* sv/pcx_rle_mono_line_expander_core.sv */
// Expands a 1-bit-per-pixel PCX run-length body into 8-pixel color words. Literal
// bytes and run count bytes are taken one per cycle while the two-entry request
// queue has room; a byte that draws n columns yields n results, one per cycle
// unless the output stalls, so a run of up to 63 repeats stalls the input once
// the queue fills. Results carry screen x and y, a flag on the last result of
// each input byte, and a flag once the image has ended; after that every byte is
// dropped until reset. The user must write registers only while the block is idle
// (the block does not enforce this); they need no clearing pass after reset.
module pcx_rle_mono_line_expander_core #(
  parameter int COLOR_BITS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pcxrle_in_if.sink                           in_ch,
  pcxrle_out_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  pcxrle_pkg::cfg_t cfg_r, cfg_nxt;
  logic             q_push;
  pcxrle_pkg::cmd_t q_push_data;
  logic             q_full;
  logic             q_pop;
  pcxrle_pkg::cmd_t q_pop_data;
  logic             q_empty;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pcxrle_pkg::REG_BYTES_PER_LINE:    cfg_nxt.bytes_per_line    = cfg_wdata[10:0];
        pcxrle_pkg::REG_LINE_TOTAL:        cfg_nxt.line_total        = cfg_wdata[12:0];
        pcxrle_pkg::REG_START_COLUMN_BYTE: cfg_nxt.start_column_byte = cfg_wdata[6:0];
        pcxrle_pkg::REG_START_ROW:         cfg_nxt.start_row         = cfg_wdata[11:0];
        pcxrle_pkg::REG_COLUMN_LIMIT:      cfg_nxt.column_limit      = cfg_wdata[6:0];
        pcxrle_pkg::REG_ROW_LIMIT:         cfg_nxt.row_limit         = cfg_wdata[11:0];
        pcxrle_pkg::REG_FG_COLOR:          cfg_nxt.fg_color          = cfg_wdata[3:0];
        pcxrle_pkg::REG_BG_COLOR:          cfg_nxt.bg_color          = cfg_wdata[3:0];
        default:                           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bytes_per_line    <= 11'd80;
      cfg_r.line_total        <= 13'd480;
      cfg_r.start_column_byte <= 7'd0;
      cfg_r.start_row         <= 12'd0;
      cfg_r.column_limit      <= 7'd80;
      cfg_r.row_limit         <= 12'd479;
      cfg_r.fg_color          <= 4'd15;
      cfg_r.bg_color          <= 4'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Byte decoder and line bookkeeping.
  pcxrle_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  // Request queue between decoder and expander.
  pcxrle_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Pixel expander and output register.
  pcxrle_back #(
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
